@@ design/cns_pkg.sv @@
// Shared types and constants for the conditional nesting stack.
package cns_pkg;

    localparam int MAX_NEST_DEFAULT = 16;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    // Statement kinds carried in the request's tuser field.
    typedef enum logic [1:0] {
        CMD_IF     = 2'd0,
        CMD_ELSE   = 2'd1,
        CMD_ELSEIF = 2'd2,
        CMD_ENDIF  = 2'd3
    } cmd_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_OVERFLOW   = 3'd1,
        ST_BAD_ELSE   = 3'd2,
        ST_BAD_ENDIF  = 3'd3,
        ST_BAD_ELSEIF = 3'd4,
        ST_TEXT       = 3'd5,
        ST_UNDERFLOW  = 3'd6
    } status_t;

    // Kind of the innermost construct at one nesting level.
    typedef enum logic [1:0] {
        LVL_IF       = 2'd0,
        LVL_ELSE     = 2'd1,
        LVL_EIF_DONE = 2'd2,
        LVL_EIF_CHK  = 2'd3
    } level_kind_t;

    // One nesting level: its construct kind, its local branch condition and
    // the enable of the level that encloses it.
    typedef struct packed {
        level_kind_t kind;
        logic        local_cond;
        logic        parent_en;
    } level_rec_t;

    typedef struct packed {
        cmd_t command;
        logic cond_value;
        logic one_line;
        logic extra_text;
        logic search_mode;
    } req_t;

    typedef struct packed {
        status_t status;
        logic    lines_enabled;
        logic    run_one_line;
    } res_t;

endpackage

@@ design/cns_in_stage.sv @@
// Input register of the conditional nesting stack.
module cns_in_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cond_value [0], one_line [1], extra_text [2], search_mode [3], zero fill
    input  logic [cns_pkg::S_TDATA_W-1:0] s_tdata,
    // command [1:0]
    input  logic [cns_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          take,
    output logic                          req_valid,
    output cns_pkg::req_t                 req
);

    logic          in_valid_reg;
    logic          in_valid_next;
    cns_pkg::req_t req_reg;
    logic          load;

    assign s_tready = !in_valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (load)
        begin
            in_valid_next = 1'b1;
        end
        else if (take)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg.command     <= cns_pkg::cmd_t'(s_tuser[1:0]);
            req_reg.cond_value  <= s_tdata[0];
            req_reg.one_line    <= s_tdata[1];
            req_reg.extra_text  <= s_tdata[2];
            req_reg.search_mode <= s_tdata[3];
        end
    end

    assign req_valid = in_valid_reg;
    assign req       = req_reg;

endmodule

@@ design/cns_core.sv @@
// Nesting state, level memory and per-statement decision logic.
module cns_core #(
    parameter int MAX_NEST = cns_pkg::MAX_NEST_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  cns_pkg::req_t req,
    output cns_pkg::res_t res
);

    localparam int DEPTH_W = $clog2(MAX_NEST + 1);
    localparam int ADDR_W  = $clog2(MAX_NEST);

    // Level memory; the innermost level is also kept in top_reg.
    cns_pkg::level_rec_t level_mem [MAX_NEST];
    cns_pkg::level_rec_t top_reg;

    logic [DEPTH_W-1:0] cond_depth_reg;
    logic [DEPTH_W-1:0] cond_depth_next;
    logic [DEPTH_W-1:0] search_depth_reg;
    logic [DEPTH_W-1:0] search_depth_next;

    logic                top_valid;
    logic                cur_en;
    logic                full;
    logic [ADDR_W-1:0]   top_addr;
    logic [ADDR_W-1:0]   push_addr;
    logic [ADDR_W-1:0]   below_addr;
    logic [DEPTH_W-1:0]  depth_minus2;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    cns_pkg::level_rec_t wr_rec;
    logic                pop;
    logic                chk;
    logic                done_already;
    logic                active;
    cns_pkg::status_t    status;
    logic                run;
    logic                en_after;

    assign top_valid    = (cond_depth_reg != '0);
    assign cur_en       = top_valid ? (top_reg.local_cond & top_reg.parent_en) : 1'b1;
    assign full         = (cond_depth_reg == DEPTH_W'(MAX_NEST));
    assign push_addr    = cond_depth_reg[ADDR_W-1:0];
    assign top_addr     = ADDR_W'(cond_depth_reg - DEPTH_W'(1));
    assign depth_minus2 = cond_depth_reg - DEPTH_W'(2);
    assign below_addr   = depth_minus2[ADDR_W-1:0];

    // Within an ELSE-IF, the condition is looked at only when the enclosing
    // level is enabled and no earlier branch has been taken.
    assign chk          = !cur_en && top_reg.parent_en;
    assign active       = chk && req.cond_value;
    assign done_already = (top_reg.kind == cns_pkg::LVL_EIF_DONE) || top_reg.local_cond;

    always_comb
    begin
        status            = cns_pkg::ST_OK;
        run               = 1'b0;
        wr_en             = 1'b0;
        wr_addr           = top_addr;
        wr_rec            = top_reg;
        pop               = 1'b0;
        cond_depth_next   = cond_depth_reg;
        search_depth_next = search_depth_reg;
        en_after          = cur_en;

        case (req.command)
            cns_pkg::CMD_IF:
            begin
                if (req.search_mode)
                begin
                    if (!req.one_line)
                    begin
                        if (search_depth_reg == DEPTH_W'(MAX_NEST))
                        begin
                            status = cns_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            search_depth_next = search_depth_reg + DEPTH_W'(1);
                        end
                    end
                end
                else if (cur_en && req.extra_text)
                begin
                    status = cns_pkg::ST_TEXT;
                end
                else if (req.one_line)
                begin
                    run = cur_en && req.cond_value;
                end
                else if (full)
                begin
                    status = cns_pkg::ST_OVERFLOW;
                end
                else
                begin
                    wr_en             = 1'b1;
                    wr_addr           = push_addr;
                    wr_rec.kind       = cns_pkg::LVL_IF;
                    wr_rec.local_cond = cur_en && req.cond_value;
                    wr_rec.parent_en  = cur_en;
                    cond_depth_next   = cond_depth_reg + DEPTH_W'(1);
                    en_after          = cur_en && req.cond_value;
                end
            end

            cns_pkg::CMD_ELSE:
            begin
                if (!req.search_mode)
                begin
                    if (!top_valid || top_reg.kind == cns_pkg::LVL_ELSE)
                    begin
                        status = cns_pkg::ST_BAD_ELSE;
                    end
                    else if (req.extra_text)
                    begin
                        status = cns_pkg::ST_TEXT;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_rec.kind = cns_pkg::LVL_ELSE;
                        if (top_reg.kind == cns_pkg::LVL_IF)
                        begin
                            wr_rec.local_cond = !top_reg.local_cond;
                        end
                        else
                        begin
                            wr_rec.local_cond = (top_reg.kind == cns_pkg::LVL_EIF_CHK);
                        end
                        en_after = wr_rec.local_cond && top_reg.parent_en;
                    end
                end
            end

            cns_pkg::CMD_ELSEIF:
            begin
                if (!req.search_mode)
                begin
                    if (!top_valid)
                    begin
                        status = req.extra_text ? cns_pkg::ST_TEXT : cns_pkg::ST_BAD_ELSEIF;
                    end
                    else if (chk && req.extra_text)
                    begin
                        status = cns_pkg::ST_TEXT;
                    end
                    else if (top_reg.kind == cns_pkg::LVL_ELSE)
                    begin
                        status = cns_pkg::ST_BAD_ELSEIF;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        if (done_already)
                        begin
                            wr_rec.kind       = cns_pkg::LVL_EIF_DONE;
                            wr_rec.local_cond = 1'b0;
                        end
                        else if (active)
                        begin
                            wr_rec.kind       = cns_pkg::LVL_EIF_DONE;
                            wr_rec.local_cond = 1'b1;
                        end
                        else
                        begin
                            wr_rec.kind       = cns_pkg::LVL_EIF_CHK;
                            wr_rec.local_cond = 1'b0;
                        end
                        en_after = wr_rec.local_cond && top_reg.parent_en;
                    end
                end
            end

            cns_pkg::CMD_ENDIF:
            begin
                if (req.search_mode && search_depth_reg != '0)
                begin
                    search_depth_next = search_depth_reg - DEPTH_W'(1);
                end
                else if (!top_valid)
                begin
                    status = cns_pkg::ST_BAD_ENDIF;
                end
                else if (req.extra_text)
                begin
                    status = cns_pkg::ST_TEXT;
                end
                else
                begin
                    pop             = 1'b1;
                    cond_depth_next = cond_depth_reg - DEPTH_W'(1);
                    en_after        = top_reg.parent_en;
                end
            end

            default:
            begin
                status = cns_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cond_depth_reg   <= '0;
            search_depth_reg <= '0;
        end
        else if (fire)
        begin
            cond_depth_reg   <= cond_depth_next;
            search_depth_reg <= search_depth_next;
        end
    end

    // The written record always becomes the new innermost level; after a pop
    // the level below is fetched from the memory.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (wr_en)
            begin
                level_mem[wr_addr] <= wr_rec;
                top_reg            <= wr_rec;
            end
            else if (pop)
            begin
                top_reg <= level_mem[below_addr];
            end
        end
    end

    assign res.status        = status;
    assign res.lines_enabled = en_after;
    assign res.run_one_line  = run;

endmodule

@@ design/cns_out_stage.sv @@
// Result register of the conditional nesting stack.
module cns_out_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  cns_pkg::res_t                 res,
    output logic                          free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status [2:0], lines_enabled [3], run_one_line [4], zero fill
    output logic [cns_pkg::M_TDATA_W-1:0] m_tdata
);

    logic          out_valid_reg;
    logic          out_valid_next;
    cns_pkg::res_t res_reg;

    assign free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, res_reg.run_one_line, res_reg.lines_enabled,
                       3'(res_reg.status)};

endmodule

@@ design/conditional_nesting_stack.sv @@
// Top level of the conditional nesting stack for IF / ELSE / ELSE-IF / END-IF.
//
// Each request on the slave stream is one statement: tuser carries the
// statement kind and tdata its evaluated condition and flags. For every
// request the master stream returns exactly one result: a status code,
// whether following lines are enabled, and whether a one-line IF's command
// runs now. Nesting levels live in a small memory with the innermost level
// held in a register, so a statement is at most one push, replace or pop.
//
// A request accepted into the input register is decided once the result
// register can take it, and its result is then offered from the result
// register. Throughput is one statement per cycle while the receiver does
// not stall; the innermost-level register and the depth counters are
// updated in the same cycle as the result register is loaded.
//
// Reset clears the nesting depth and the search-mode depth, so lines are
// enabled and no construct is open; the level memory is not cleared.
// When the receiver stalls, the result register holds its result and the
// input register keeps one further request; s_tready drops only once both
// are full.
module conditional_nesting_stack #(
    parameter int MAX_NEST = cns_pkg::MAX_NEST_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cond_value [0], one_line [1], extra_text [2], search_mode [3], zero fill
    input  logic [cns_pkg::S_TDATA_W-1:0] s_tdata,
    // command [1:0]
    input  logic [cns_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status [2:0], lines_enabled [3], run_one_line [4], zero fill
    output logic [cns_pkg::M_TDATA_W-1:0] m_tdata
);

    logic          req_valid;
    cns_pkg::req_t req;
    cns_pkg::res_t res;
    logic          out_free;
    logic          fire;

    // A held request is decided whenever the result register can take it.
    assign fire = req_valid && out_free;

    cns_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .take      (fire),
        .req_valid (req_valid),
        .req       (req)
    );

    cns_core #(
        .MAX_NEST (MAX_NEST)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (req),
        .res   (res)
    );

    cns_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
